// File: hw/rtl/bpmpic_pkg.sv
// ----------------------------------------------------------------------------
// bpmpic_pkg
// Shared types, codes and constants of the beam position / intensity core.
// ----------------------------------------------------------------------------
`default_nettype none

package bpmpic_pkg;

    // Default electrode sample width
    localparam int SIGNAL_BITS_DEF = 16;

    // Width of the electrode ports
    localparam int ELECTRODE_W = 16;

    // Width of the Q1.15 quotient and of the positions
    localparam int Q_BITS = 16;

    // Intensity output width
    localparam int INTEN_W = 18;

    // Divider: quotient bits retired per stage and number of stages
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = Q_BITS / DIV_BPS;

    // Square root: radicand width, root bits per stage, stages
    localparam int RAD_W       = 32;
    localparam int SQRT_BPS    = 2;
    localparam int SQRT_STAGES = (RAD_W / 2) / SQRT_BPS;

    // Calibration polynomial latency
    localparam int CAL_LAT = 6;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CAL_MODE = 1'b0;

    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_SMALL = 2'd1,
        MODE_BIG   = 2'd2,
        MODE_OFF   = 2'd3
    } cal_mode_t;

    // Q8.16 polynomial coefficients: pos = h * (c0 + c2*h^2 + c4*h^4)
    typedef struct packed {
        logic signed [23:0] c0;
        logic signed [23:0] c2;
        logic signed [23:0] c4;
    } coef_t;

    localparam coef_t COEF_X = '{c0: 24'sd801505, c2: -24'sd124518, c4: 24'sd983040};
    localparam coef_t COEF_Y = '{c0: 24'sd1422131, c2: 24'sd3080192, c4: 24'sd0};
    localparam coef_t COEF_BIG = '{c0: 24'sd1245184, c2: 24'sd917504, c4: 24'sd0};

endpackage

`default_nettype wire

// File: hw/rtl/bpm_position_intensity_calc_core.sv
// ----------------------------------------------------------------------------
// bpm_position_intensity_calc_core
// Difference-over-sum beam position and intensity from four pickup
// electrode amplitudes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction of four
//   electrode amplitudes. Output channel (out_valid / out_stall) carries
//   horizontal_position, vertical_position and beam_intensity.
//   Throughput is one transaction per cycle while the output is not stalled.
//   An accepted input transaction passes through two input stages, eight
//   divider stages (two quotient bits each), one sign stage, one square
//   stage, eight square root stages and the output register.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises in the same cycle; bubbles do not collapse.
//   calibration_mode is written over the APB port at byte address 0. The user
//   must change it only while the pipeline is empty; the block does not
//   enforce this. Reset clears all valid bits and sets the mode to raw normalized output.
// ----------------------------------------------------------------------------
`default_nettype none

module bpm_position_intensity_calc_core #(
    parameter int SIGNAL_BITS = bpmpic_pkg::SIGNAL_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,

    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic [bpmpic_pkg::ELECTRODE_W-1:0]       electrode_a,
    input  wire logic [bpmpic_pkg::ELECTRODE_W-1:0]       electrode_b,
    input  wire logic [bpmpic_pkg::ELECTRODE_W-1:0]       electrode_c,
    input  wire logic [bpmpic_pkg::ELECTRODE_W-1:0]       electrode_d,

    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic signed [bpmpic_pkg::Q_BITS-1:0]          horizontal_position,
    output logic signed [bpmpic_pkg::Q_BITS-1:0]          vertical_position,
    output logic        [bpmpic_pkg::INTEN_W-1:0]         beam_intensity,

    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [bpmpic_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [bpmpic_pkg::APB_DATA_W-1:0]        pwdata,
    output logic      [bpmpic_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                          pready
);

    localparam int EW = (SIGNAL_BITS < bpmpic_pkg::ELECTRODE_W) ? SIGNAL_BITS
                                                                : bpmpic_pkg::ELECTRODE_W;
    localparam int DW = EW + 2;
    localparam int QW = bpmpic_pkg::Q_BITS;
    localparam int IW = bpmpic_pkg::INTEN_W;

    localparam int IDX_DIV_OUT = 1 + bpmpic_pkg::DIV_STAGES;
    localparam int IDX_HV      = IDX_DIV_OUT + 1;
    localparam int IDX_RAD     = IDX_HV + 1;
    localparam int IDX_SQ_OUT  = IDX_RAD + bpmpic_pkg::SQRT_STAGES;
    localparam int IDX_CAL_OUT = IDX_HV + bpmpic_pkg::CAL_LAT;
    localparam int CAL_DLY     = IDX_SQ_OUT - IDX_CAL_OUT;
    localparam int IDX_OUT     = IDX_SQ_OUT + 1;

    typedef struct packed {
        logic          neg_h;
        logic          neg_v;
        logic          zero_h;
        logic          zero_v;
        logic [IW-1:0] sat_sum;
    } pre_t;

    typedef struct packed {
        logic signed [QW-1:0] h;
        logic signed [QW-1:0] v;
        logic        [IW-1:0] sat_sum;
    } lane_t;

    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
    } cal_t;

    function automatic logic signed [15:0] apply_sign(input logic [15:0] q,
                                                      input logic neg,
                                                      input logic zero);
        logic signed [15:0] r;
        if (zero)
        begin
            r = '0;
        end
        else if (neg)
        begin
            r = q[15] ? -16'sd32768 : 16'(-$signed({1'b0, q}));
        end
        else
        begin
            r = q[15] ? 16'sd32767 : $signed(q);
        end
        return r;
    endfunction

    bpmpic_pkg::cal_mode_t cal_mode_reg;
    logic                  cfg_write;

    logic                  adv;
    logic [IDX_OUT:0]      vld_reg;

    logic [EW-1:0]         a_reg;
    logic [EW-1:0]         b_reg;
    logic [EW-1:0]         c_reg;
    logic [EW-1:0]         d_reg;

    logic signed [DW:0]    as_s;
    logic signed [DW:0]    bs_s;
    logic signed [DW:0]    cs_s;
    logic signed [DW:0]    ds_s;
    logic signed [DW:0]    num_h;
    logic signed [DW:0]    num_v;
    logic [DW-1:0]         sum;
    logic [DW-1:0]         den_h;
    logic [DW-1:0]         den_v;
    logic                  mode_big;
    pre_t                  pre_next;

    logic [DW-1:0]         magh_reg;
    logic [DW-1:0]         denh_reg;
    logic [DW-1:0]         magv_reg;
    logic [DW-1:0]         denv_reg;
    pre_t                  pre_reg [1:IDX_DIV_OUT];

    logic [QW-1:0]         quo_h;
    logic [QW-1:0]         quo_v;
    lane_t                 lane_next;
    lane_t                 lane_reg [IDX_HV:IDX_SQ_OUT];

    logic signed [31:0]    hh;
    logic signed [31:0]    vv;
    logic [bpmpic_pkg::RAD_W-1:0]   rad_reg;
    logic [bpmpic_pkg::RAD_W/2-1:0] root;

    bpmpic_pkg::coef_t     coef_x;
    bpmpic_pkg::coef_t     coef_y;
    cal_t                  cal_out;
    cal_t                  cal_reg [1:CAL_DLY];

    logic signed [QW-1:0]  x_next;
    logic signed [QW-1:0]  y_next;
    logic [IW-1:0]         inten_next;
    logic signed [QW-1:0]  horizontal_position_reg;
    logic signed [QW-1:0]  vertical_position_reg;
    logic [IW-1:0]         beam_intensity_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == bpmpic_pkg::REG_CAL_MODE)
                       ? bpmpic_pkg::APB_DATA_W'(cal_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_mode_reg <= bpmpic_pkg::MODE_RAW;
        end
        else if (cfg_write && (paddr[2] == bpmpic_pkg::REG_CAL_MODE))
        begin
            cal_mode_reg <= bpmpic_pkg::cal_mode_t'(pwdata[1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Flow control: the pipeline moves as one unless the output is held
    // ------------------------------------------------------------------
    assign adv      = !(vld_reg[IDX_OUT] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[IDX_OUT-1:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Input register and divider operands
    // ------------------------------------------------------------------
    assign mode_big = (cal_mode_reg == bpmpic_pkg::MODE_BIG);
    assign as_s     = $signed((DW+1)'(a_reg));
    assign bs_s     = $signed((DW+1)'(b_reg));
    assign cs_s     = $signed((DW+1)'(c_reg));
    assign ds_s     = $signed((DW+1)'(d_reg));
    assign sum      = DW'(a_reg) + DW'(b_reg) + DW'(c_reg) + DW'(d_reg);

    // Big pickups use two-electrode ratios with their own divisors
    assign num_h = mode_big ? (as_s - cs_s) : (as_s - bs_s - cs_s + ds_s);
    assign num_v = mode_big ? (bs_s - ds_s) : (as_s + bs_s - cs_s - ds_s);
    assign den_h = mode_big ? (DW'(a_reg) + DW'(c_reg)) : sum;
    assign den_v = mode_big ? (DW'(b_reg) + DW'(d_reg)) : sum;

    always_comb
    begin
        pre_next.neg_h   = num_h[DW];
        pre_next.neg_v   = num_v[DW];
        pre_next.zero_h  = (den_h == '0);
        pre_next.zero_v  = (den_v == '0);
        pre_next.sat_sum = IW'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg      <= electrode_a[EW-1:0];
            b_reg      <= electrode_b[EW-1:0];
            c_reg      <= electrode_c[EW-1:0];
            d_reg      <= electrode_d[EW-1:0];

            magh_reg   <= num_h[DW] ? DW'(-num_h) : DW'(num_h);
            magv_reg   <= num_v[DW] ? DW'(-num_v) : DW'(num_v);
            denh_reg   <= den_h;
            denv_reg   <= den_v;
            pre_reg[1] <= pre_next;
            for (int k = 2; k <= IDX_DIV_OUT; k++)
            begin
                pre_reg[k] <= pre_reg[k-1];
            end
        end
    end

    bpmpic_div #(.DW(DW)) u_div_h (
        .clk (clk),
        .en  (adv),
        .mag (magh_reg),
        .den (denh_reg),
        .quo (quo_h)
    );

    bpmpic_div #(.DW(DW)) u_div_v (
        .clk (clk),
        .en  (adv),
        .mag (magv_reg),
        .den (denv_reg),
        .quo (quo_v)
    );

    // ------------------------------------------------------------------
    // Signed normalized offsets, squares and calibration
    // ------------------------------------------------------------------
    always_comb
    begin
        lane_next.h       = apply_sign(quo_h, pre_reg[IDX_DIV_OUT].neg_h,
                                       pre_reg[IDX_DIV_OUT].zero_h);
        lane_next.v       = apply_sign(quo_v, pre_reg[IDX_DIV_OUT].neg_v,
                                       pre_reg[IDX_DIV_OUT].zero_v);
        lane_next.sat_sum = pre_reg[IDX_DIV_OUT].sat_sum;
    end

    assign hh = lane_reg[IDX_HV].h * lane_reg[IDX_HV].h;
    assign vv = lane_reg[IDX_HV].v * lane_reg[IDX_HV].v;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg[IDX_HV] <= lane_next;
            for (int k = IDX_HV + 1; k <= IDX_SQ_OUT; k++)
            begin
                lane_reg[k] <= lane_reg[k-1];
            end
            rad_reg    <= $unsigned(hh) + $unsigned(vv);
            cal_reg[1] <= cal_out;
            for (int k = 2; k <= CAL_DLY; k++)
            begin
                cal_reg[k] <= cal_reg[k-1];
            end
        end
    end

    bpmpic_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (rad_reg),
        .root (root)
    );

    always_comb
    begin
        if (mode_big)
        begin
            coef_x = bpmpic_pkg::COEF_BIG;
            coef_y = bpmpic_pkg::COEF_BIG;
        end
        else
        begin
            coef_x = bpmpic_pkg::COEF_X;
            coef_y = bpmpic_pkg::COEF_Y;
        end
    end

    bpmpic_calib u_calib_x (
        .clk  (clk),
        .en   (adv),
        .h    (lane_reg[IDX_HV].h),
        .coef (coef_x),
        .pos  (cal_out.x)
    );

    bpmpic_calib u_calib_y (
        .clk  (clk),
        .en   (adv),
        .h    (lane_reg[IDX_HV].v),
        .coef (coef_y),
        .pos  (cal_out.y)
    );

    // ------------------------------------------------------------------
    // Output select and register
    // ------------------------------------------------------------------
    always_comb
    begin
        case (cal_mode_reg)
            bpmpic_pkg::MODE_RAW:
            begin
                x_next     = lane_reg[IDX_SQ_OUT].h;
                y_next     = lane_reg[IDX_SQ_OUT].v;
                inten_next = IW'(root);
            end
            bpmpic_pkg::MODE_SMALL,
            bpmpic_pkg::MODE_BIG:
            begin
                x_next     = cal_reg[CAL_DLY].x;
                y_next     = cal_reg[CAL_DLY].y;
                inten_next = lane_reg[IDX_SQ_OUT].sat_sum;
            end
            default:
            begin
                x_next     = '0;
                y_next     = '0;
                inten_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            horizontal_position_reg <= x_next;
            vertical_position_reg   <= y_next;
            beam_intensity_reg      <= inten_next;
        end
    end

    assign out_valid           = vld_reg[IDX_OUT];
    assign horizontal_position = horizontal_position_reg;
    assign vertical_position   = vertical_position_reg;
    assign beam_intensity      = beam_intensity_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bpmpic_div.sv
// ----------------------------------------------------------------------------
// bpmpic_div
// Pipelined restoring divider: quo = floor((mag*2^15 + den/2) / den),
// two quotient bits per stage. Requires mag <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmpic_div #(
    parameter int DW = 18
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [DW-1:0]                     mag,
    input  wire logic [DW-1:0]                     den,
    output logic      [bpmpic_pkg::Q_BITS-1:0]     quo
);

    localparam int QW  = bpmpic_pkg::Q_BITS;
    localparam int NST = bpmpic_pkg::DIV_STAGES;
    localparam int BPS = bpmpic_pkg::DIV_BPS;

    logic [DW+QW-1:0] numer;

    logic [DW-1:0] rem_reg [NST-1];
    logic [QW-1:0] low_reg [NST-1];
    logic [DW-1:0] den_reg [NST-1];
    logic [QW-1:0] q_reg   [NST];

    assign numer = (DW+QW)'({mag, {(QW-1){1'b0}}}) + (DW+QW)'(den >> 1);

    for (genvar i = 0; i < NST; i++) begin : g_st
        logic [DW-1:0] rem_src;
        logic [QW-1:0] low_src;
        logic [QW-1:0] q_src;
        logic [DW-1:0] den_src;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] low_next;
        logic [QW-1:0] q_next;

        if (i == 0) begin : g_first
            assign rem_src = numer[DW+QW-1:QW];
            assign low_src = numer[QW-1:0];
            assign q_src   = '0;
            assign den_src = den;
        end
        else begin : g_rest
            assign rem_src = rem_reg[i-1];
            assign low_src = low_reg[i-1];
            assign q_src   = q_reg[i-1];
            assign den_src = den_reg[i-1];
        end

        always_comb
        begin
            logic [DW:0] t;
            rem_next = rem_src;
            low_next = low_src;
            q_next   = q_src;
            for (int j = 0; j < BPS; j++)
            begin
                t        = {rem_next, low_next[QW-1]};
                low_next = {low_next[QW-2:0], 1'b0};
                if (t >= {1'b0, den_src})
                begin
                    t      = t - {1'b0, den_src};
                    q_next = {q_next[QW-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_next[QW-2:0], 1'b0};
                end
                rem_next = t[DW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i] <= q_next;
            end
        end

        if (i < NST-1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    low_reg[i] <= low_next;
                    den_reg[i] <= den_src;
                end
            end
        end
    end

    assign quo = q_reg[NST-1];

endmodule

`default_nettype wire

// File: hw/rtl/bpmpic_isqrt.sv
// ----------------------------------------------------------------------------
// bpmpic_isqrt
// Pipelined digit-by-digit square root of a 32-bit radicand, two root bits
// per stage, rounded to nearest at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmpic_isqrt (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [bpmpic_pkg::RAD_W-1:0]        rad,
    output logic      [bpmpic_pkg::RAD_W/2-1:0]      root
);

    localparam int RW  = bpmpic_pkg::RAD_W;
    localparam int OW  = RW / 2;
    localparam int XW  = OW + 2;
    localparam int NST = bpmpic_pkg::SQRT_STAGES;
    localparam int BPS = bpmpic_pkg::SQRT_BPS;

    logic [RW-1:0] rad_reg [NST-1];
    logic [XW-1:0] x_reg   [NST];
    logic [OW-1:0] r_reg   [NST];

    for (genvar i = 0; i < NST; i++) begin : g_st
        logic [RW-1:0] rad_src;
        logic [XW-1:0] x_src;
        logic [OW-1:0] r_src;
        logic [RW-1:0] rad_next;
        logic [XW-1:0] x_next;
        logic [OW-1:0] r_next;

        if (i == 0) begin : g_first
            assign rad_src = rad;
            assign x_src   = '0;
            assign r_src   = '0;
        end
        else begin : g_rest
            assign rad_src = rad_reg[i-1];
            assign x_src   = x_reg[i-1];
            assign r_src   = r_reg[i-1];
        end

        always_comb
        begin
            logic [XW+1:0] xs;
            logic [XW+1:0] t;
            rad_next = rad_src;
            x_next   = x_src;
            r_next   = r_src;
            for (int j = 0; j < BPS; j++)
            begin
                xs       = {x_next, rad_next[RW-1:RW-2]};
                rad_next = {rad_next[RW-3:0], 2'b00};
                t        = (XW+2)'({r_next, 2'b01});
                if (xs >= t)
                begin
                    xs     = xs - t;
                    r_next = {r_next[OW-2:0], 1'b1};
                end
                else
                begin
                    r_next = {r_next[OW-2:0], 1'b0};
                end
                x_next = xs[XW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                r_reg[i] <= r_next;
            end
        end

        if (i < NST-1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[i] <= rad_next;
                end
            end
        end
    end

    // Remainder above the root means the true root lies past the half point
    assign root = r_reg[NST-1] + OW'(x_reg[NST-1] > XW'(r_reg[NST-1]));

endmodule

`default_nettype wire

// File: hw/rtl/bpmpic_calib.sv
// ----------------------------------------------------------------------------
// bpmpic_calib
// Odd calibration polynomial h*(c0 + c2*h^2 + c4*h^4): Q1.15 in, Q8.8 out,
// six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmpic_calib (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [15:0]                 h,
    input  wire bpmpic_pkg::coef_t                  coef,
    output logic signed [15:0]                      pos
);

    logic signed [31:0] hsq_full;
    logic        [15:0] habs_next;
    logic        [15:0] h4;
    logic signed [40:0] p_full;
    logic        [53:0] mag;
    logic        [53:0] rnd;
    logic        [15:0] rmag;
    logic signed [15:0] pos_next;

    logic        [30:0] hsq_reg;
    logic        [15:0] h2_reg;
    logic        [30:0] h2sq_reg;
    logic signed [40:0] c2h2_reg;
    logic        [37:0] p_reg;
    logic        [34:0] pl_reg;
    logic        [34:0] ph_reg;
    logic        [15:0] habs_reg [4];
    logic               neg_reg  [5];
    logic signed [15:0] pos_reg;

    assign hsq_full  = h * h;
    assign habs_next = h[15] ? 16'(-h) : h;

    assign h4     = 16'((h2sq_reg + 31'd16384) >> 15);
    assign p_full = (41'(coef.c0) <<< 15) + c2h2_reg + coef.c4 * $signed({1'b0, h4});

    assign mag  = {ph_reg, 19'b0} + 54'(pl_reg);
    assign rnd  = mag + (54'(1) << 37);
    assign rmag = rnd[53:38];

    always_comb
    begin
        if (neg_reg[4])
        begin
            pos_next = (rmag > 16'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, rmag}));
        end
        else
        begin
            pos_next = (rmag > 16'd32767) ? 16'sd32767 : $signed(rmag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hsq_reg     <= hsq_full[30:0];
            habs_reg[0] <= habs_next;
            neg_reg[0]  <= h[15];

            h2_reg      <= 16'((hsq_reg + 31'd16384) >> 15);
            habs_reg[1] <= habs_reg[0];
            neg_reg[1]  <= neg_reg[0];

            h2sq_reg    <= 31'(h2_reg * h2_reg);
            c2h2_reg    <= coef.c2 * $signed({1'b0, h2_reg});
            habs_reg[2] <= habs_reg[1];
            neg_reg[2]  <= neg_reg[1];

            p_reg       <= p_full[37:0];
            habs_reg[3] <= habs_reg[2];
            neg_reg[3]  <= neg_reg[2];

            pl_reg      <= habs_reg[3] * p_reg[18:0];
            ph_reg      <= habs_reg[3] * p_reg[37:19];
            neg_reg[4]  <= neg_reg[3];

            pos_reg     <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bpmpic_chk.sv
// ----------------------------------------------------------------------------
// bpmpic_chk
// Port-level checks of the beam position / intensity core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bpmpic_chk (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_stall,
    input wire logic                                  out_valid,
    input wire logic                                  out_stall,
    input wire logic signed [bpmpic_pkg::Q_BITS-1:0]  horizontal_position,
    input wire logic signed [bpmpic_pkg::Q_BITS-1:0]  vertical_position,
    input wire logic        [bpmpic_pkg::INTEN_W-1:0] beam_intensity
);

    // Held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(horizontal_position)
            && $stable(vertical_position) && $stable(beam_intensity))
        else $error("held output transaction changed");

    // Input is held back only by a stalled, valid output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // Intensity never exceeds four full-scale amplitudes
    a_inten: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> beam_intensity <= 18'd262140)
        else $error("intensity out of range");

endmodule

bind bpm_position_intensity_calc_core bpmpic_chk u_bpmpic_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_stall            (in_stall),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .horizontal_position (horizontal_position),
    .vertical_position   (vertical_position),
    .beam_intensity      (beam_intensity)
);

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the beam position / intensity core: a directed
// table in every calibration mode and random electrode sets in random modes,
// checked against a fixed-point position predictor with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY = 20;
    localparam int N_RANDOM = 1950;

    typedef struct {
        logic signed [15:0] hpos;
        logic signed [15:0] vpos;
        logic [17:0]        inten;
    } position_t;

    typedef struct {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        bit          known;
        position_t   res;
    } sample_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] electrode_a = '0, electrode_b = '0, electrode_c = '0, electrode_d = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] horizontal_position, vertical_position;
    logic [17:0] beam_intensity;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [bpmpic_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [bpmpic_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [bpmpic_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    bpmpic_pkg::cal_mode_t mode_shadow = bpmpic_pkg::MODE_RAW;
    position_t   expected_positions[$];
    int          error_count = 0;
    int          result_count = 0;
    int          idle_pct = 24;

    bpm_position_intensity_calc_core i_dut (.*);

    always #10 clk = ~clk;

    function automatic longint ratio_q15(longint num, longint den);
        longint mag, q;
        if (den == 0)
            return 0;
        mag = (num < 0) ? -num : num;
        q = (mag * 32768 + den / 2) / den;
        if (num < 0)
            return (q >= 32768) ? -32768 : -q;
        return (q > 32767) ? 32767 : q;
    endfunction

    function automatic longint square_q15(longint h);
        return (h * h + 16384) / 32768;
    endfunction

    function automatic longint poly_mm(longint h, longint c0, longint c2, longint c4);
        longint h2, h4, p, prod, mag, r;
        h2 = square_q15(h);
        h4 = square_q15(h2);
        p = c0 * 32768 + c2 * h2 + c4 * h4;
        prod = h * p;
        mag = (prod < 0) ? -prod : prod;
        r = (mag + (64'sd1 <<< 37)) >>> 38;
        r = (prod < 0) ? -r : r;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic longint root_rounded(longint n);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= n)
            r = r + 1;
        if (n - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic position_t compute_position(logic [15:0] a, logic [15:0] b,
                                                   logic [15:0] c, logic [15:0] d);
        position_t p;
        longint sa, sb, sc, sd, s, h, v;
        sa = a; sb = b; sc = c; sd = d;
        s = sa + sb + sc + sd;
        h = ratio_q15(sa - sb - sc + sd, s);
        v = ratio_q15(sa + sb - sc - sd, s);
        p.hpos = '0; p.vpos = '0; p.inten = '0;
        case (mode_shadow)
            bpmpic_pkg::MODE_RAW:
            begin
                p.hpos = 16'(h);
                p.vpos = 16'(v);
                p.inten = 18'(root_rounded(h * h + v * v));
            end
            bpmpic_pkg::MODE_SMALL:
            begin
                p.hpos = 16'(poly_mm(h, bpmpic_pkg::COEF_X.c0, bpmpic_pkg::COEF_X.c2,
                                     bpmpic_pkg::COEF_X.c4));
                p.vpos = 16'(poly_mm(v, bpmpic_pkg::COEF_Y.c0, bpmpic_pkg::COEF_Y.c2,
                                     bpmpic_pkg::COEF_Y.c4));
                p.inten = 18'((s > 262143) ? 262143 : s);
            end
            bpmpic_pkg::MODE_BIG:
            begin
                p.hpos = 16'(poly_mm(ratio_q15(sa - sc, sa + sc), bpmpic_pkg::COEF_BIG.c0,
                                     bpmpic_pkg::COEF_BIG.c2, 0));
                p.vpos = 16'(poly_mm(ratio_q15(sb - sd, sb + sd), bpmpic_pkg::COEF_BIG.c0,
                                     bpmpic_pkg::COEF_BIG.c2, 0));
                p.inten = 18'((s > 262143) ? 262143 : s);
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    task automatic write_mode(bpmpic_pkg::cal_mode_t m);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(m);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mode_shadow = m;
    endtask

    // Hold the payload until the block takes the transaction.
    task automatic send_sample(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                               logic [15:0] d, bit known, position_t res);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        electrode_a <= a; electrode_b <= b; electrode_c <= c; electrode_d <= d;
        expected_positions.push_back(known ? res : compute_position(a, b, c, d));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_positions.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [15:0] random_electrode();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        out_stall <= (idle_pct > 0) && ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk)
    begin
        position_t exp_pos;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (expected_positions.size() == 0)
            begin
                $error("result with no transaction pending");
                error_count++;
            end
            else
            begin
                exp_pos = expected_positions.pop_front();
                if (horizontal_position !== exp_pos.hpos)
                begin
                    $error("horizontal_position exp %0d got %0d", exp_pos.hpos,
                           horizontal_position);
                    error_count++;
                end
                if (vertical_position !== exp_pos.vpos)
                begin
                    $error("vertical_position exp %0d got %0d", exp_pos.vpos,
                           vertical_position);
                    error_count++;
                end
                if (beam_intensity !== exp_pos.inten)
                begin
                    $error("beam_intensity exp %0d got %0d", exp_pos.inten, beam_intensity);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sample_row_t rows[$];
        position_t   zero_pos;
        bpmpic_pkg::cal_mode_t m;
        zero_pos = '{hpos: 16'sd0, vpos: 16'sd0, inten: 18'd0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: zero sum, extremes, one-hot electrodes, broken pairs.
        rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, zero_pos});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, zero_pos});
        rows.push_back('{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                         '{16'sd32767, 16'sd32767, 18'd46340}});
        rows.push_back('{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1,
                         '{-16'sd32768, -16'sd32768, 18'd46341}});
        rows.push_back('{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, zero_pos});
        rows.push_back('{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, zero_pos});
        rows.push_back('{16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, zero_pos});
        rows.push_back('{16'h0000, 16'h0001, 16'h0000, 16'h0001, 1'b0, zero_pos});
        rows.push_back('{16'h1234, 16'h0000, 16'h1234, 16'h0000, 1'b0, zero_pos});
        rows.push_back('{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0, zero_pos});
        rows.push_back('{16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 1'b0, zero_pos});
        rows.push_back('{16'd3, 16'd1, 16'd1, 16'd1, 1'b0, zero_pos});
        for (int k = 0; k < 4; k++)
        begin
            m = bpmpic_pkg::cal_mode_t'(k);
            write_mode(m);
            foreach (rows[i])
                send_sample(rows[i].a, rows[i].b, rows[i].c, rows[i].d,
                            rows[i].known && m == bpmpic_pkg::MODE_RAW, rows[i].res);
            drain();
        end

        // Random phases; the first one runs without any idling.
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : 24;
            write_mode(bpmpic_pkg::cal_mode_t'((ph == 7) ? 3 : $urandom_range(3)));
            for (int n = 0; n < N_RANDOM / 8; n++)
                send_sample(random_electrode(), random_electrode(),
                            random_electrode(), random_electrode(), 1'b0, zero_pos);
            drain();
        end
        write_mode(bpmpic_pkg::MODE_RAW);

        $display("Covered all four calibration modes, zero and full-scale sums,");
        $display("and %0d checked results under random stalls.", result_count);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/bpmpic_pkg.sv
hw/rtl/bpmpic_div.sv
hw/rtl/bpmpic_isqrt.sv
hw/rtl/bpmpic_calib.sv
hw/rtl/bpm_position_intensity_calc_core.sv
hw/rtl/bpmpic_chk.sv
verif/tb.sv
